[hdl/mst_pkg.sv]
// ---------------------------------------------------------------------------
// mst_pkg: shared types and constants of the multi-slot second timer
// request and response items, slot modes, sequencer states, rounding constants
// ---------------------------------------------------------------------------
package mst_pkg;

    localparam int MS_W   = 32;         // duration field width in ms
    localparam int DIV_W  = MS_W + 1;   // rounded dividend, no overflow

    localparam logic [DIV_W-1:0] ROUND_MS = DIV_W'(900);

    // one thousand is eight times 125: drop three low bits, then multiply
    // by ceil(2^37 / 125) and keep the bits from 37 up
    localparam int               SEC_SHIFT   = 3;
    localparam int               RECIP_W     = 31;
    localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;
    localparam int               RECIP_SHIFT = 37;

    // request command codes
    localparam logic CMD_CREATE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // repeat mode codes of a create
    localparam logic REPEAT_PERIODIC = 1'b0;
    localparam logic REPEAT_ONESHOT  = 1'b1;

    // response kind codes
    localparam logic KIND_CREATE = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [1:0] {
        MODE_FREE     = 2'd0,
        MODE_PERIODIC = 2'd1,
        MODE_ONESHOT  = 2'd2
    } slot_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CREATE,
        ST_TICK,
        ST_TICK_END
    } mst_state_t;

    typedef struct packed {
        logic            cmd;
        logic            repeat_mode;
        logic [MS_W-1:0] duration_ms;
    } req_item_t;

    typedef struct packed {
        logic       kind;
        logic [4:0] timer_id;
        logic       create_ok;
        logic       last;
    } rsp_item_t;

endpackage

[hdl/mst_sec_div.sv]
// ---------------------------------------------------------------------------
// mst_sec_div: millisecond to second rounding unit
// (ms + 900) / 1000 as a registered add, a shift and a reciprocal multiply,
// then clamp to at least one second and at most the counter range
// ---------------------------------------------------------------------------
module mst_sec_div #(
    parameter int COUNT_WIDTH = 23
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mst_pkg::MS_W-1:0]  duration_ms,
    output logic                      busy,
    output logic [COUNT_WIDTH-1:0]    secs
);

    localparam int Y_W    = mst_pkg::DIV_W - mst_pkg::SEC_SHIFT;
    localparam int PROD_W = Y_W + mst_pkg::RECIP_W;
    localparam int Q_W    = PROD_W - mst_pkg::RECIP_SHIFT;
    localparam int CMP_W  = Q_W + COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [mst_pkg::DIV_W-1:0] sum_reg, sum_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic                      mul_reg, mul_next;
    logic [CMP_W-1:0]          quo_wide;
    logic [CMP_W-1:0]          max_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg <= 1'b0;
        end
        else
        begin
            mul_reg <= mul_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
    end

    // the start adds the rounding offset into sum_reg, then the registered sum is multiplied
    always_comb
    begin
        sum_next  = sum_reg;
        prod_next = prod_reg;
        mul_next  = 1'b0;
        if (start)
        begin
            sum_next = {1'b0, duration_ms} + mst_pkg::ROUND_MS;
            mul_next = 1'b1;
        end
        if (mul_reg)
        begin
            prod_next = {{mst_pkg::RECIP_W{1'b0}}, sum_reg[mst_pkg::DIV_W-1:mst_pkg::SEC_SHIFT]}
                      * {{Y_W{1'b0}}, mst_pkg::RECIP_125};
        end
    end

    assign busy     = mul_reg;
    assign quo_wide = CMP_W'(prod_reg[PROD_W-1:mst_pkg::RECIP_SHIFT]);
    assign max_wide = CMP_W'(COUNT_MAX);

    // zero seconds raised to one, long durations saturate
    always_comb
    begin
        if (quo_wide == '0)
        begin
            secs = COUNT_WIDTH'(1);
        end
        else if (quo_wide > max_wide)
        begin
            secs = COUNT_MAX;
        end
        else
        begin
            secs = quo_wide[COUNT_WIDTH-1:0];
        end
    end

endmodule

[hdl/multi_slot_second_timer_unit.sv]
// ---------------------------------------------------------------------------
// multi_slot_second_timer_unit: table of periodic and one-shot second timers
// create items allocate the lowest free slot, tick items count every active
// slot down and report the slots that reach zero in slot order
// ---------------------------------------------------------------------------
//
//  channel  | signals                   | payload      | direction
//  ---------+---------------------------+--------------+----------
//  request  | req_valid, req_ready      | req_item_t   | into block
//  response | rsp_valid, rsp_ready      | rsp_item_t   | out of block
//
// create: the reply waits for the free-slot scan, which checks one slot a
//   cycle from slot zero up to the first free slot or the end of the table;
//   the rounding unit runs alongside it
// tick: one slot a cycle unless an expiry stalls, through the shared decrement
//   unit and the single read port and single write port of the count memories
// one item at a time: req_ready is high only while the sequencer is idle
// a stalled response holds the walk only when a second expiry needs the
//   output register; the pending expiry is held back to mark the last one
// reset clears the slot mode flops at once; the count memories need no clear
// ---------------------------------------------------------------------------
module multi_slot_second_timer_unit #(
    parameter int SLOTS       = 32,
    parameter int COUNT_WIDTH = 23
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  mst_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mst_pkg::rsp_item_t rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] SCAN_END  = CNT_W'(SLOTS);

    // slot id to the 5-bit id field, wider tables wrap
    function automatic logic [4:0] to_id(input logic [IDX_W-1:0] idx);
        logic [IDX_W+4:0] wide;
        wide = {5'b0, idx};
        return wide[4:0];
    endfunction

    // sequencer state
    mst_pkg::mst_state_t state_reg, state_next;
    logic [IDX_W-1:0]    ex_idx_reg, ex_idx_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                scan_found_reg, scan_found_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_id_reg, pend_id_next;
    logic                mode_oneshot_reg, mode_oneshot_next;

    // output register
    logic                rsp_valid_reg, rsp_valid_next;
    mst_pkg::rsp_item_t  rsp_reg, rsp_next;

    // slot table: modes in flops, counts in memories
    mst_pkg::slot_mode_t     mode_reg [SLOTS];
    logic [COUNT_WIDTH-1:0]  rem_mem  [SLOTS];
    logic [COUNT_WIDTH-1:0]  rel_mem  [SLOTS];
    logic [COUNT_WIDTH-1:0]  rem_rd_reg;
    logic [COUNT_WIDTH-1:0]  rel_rd_reg;

    logic                    mode_we;
    logic [IDX_W-1:0]        mode_wa;
    mst_pkg::slot_mode_t     mode_wd;
    logic                    rem_we;
    logic                    rel_we;
    logic [IDX_W-1:0]        mem_wa;
    logic [COUNT_WIDTH-1:0]  rem_wd;
    logic [IDX_W-1:0]        rd_idx;

    // rounding unit
    logic                    div_start;
    logic                    div_busy;
    logic [COUNT_WIDTH-1:0]  div_secs;

    // walk helpers
    logic                    out_free;
    logic                    scan_done;
    logic                    scan_free;
    mst_pkg::slot_mode_t     ex_mode;
    logic [COUNT_WIDTH-1:0]  rem_dec;
    logic                    ex_last;

    mst_sec_div #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .duration_ms(req.duration_ms),
        .busy       (div_busy),
        .secs       (div_secs)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mst_pkg::ST_IDLE;
            scan_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                mode_reg[i] <= mst_pkg::MODE_FREE;
            end
        end
        else
        begin
            state_reg      <= state_next;
            scan_found_reg <= scan_found_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (mode_we)
            begin
                mode_reg[mode_wa] <= mode_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ex_idx_reg       <= ex_idx_next;
        scan_idx_reg     <= scan_idx_next;
        pend_id_reg      <= pend_id_next;
        mode_oneshot_reg <= mode_oneshot_next;
        rsp_reg          <= rsp_next;
    end

    // count memories, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[mem_wa] <= rem_wd;
        end
        if (rel_we)
        begin
            rel_mem[mem_wa] <= div_secs;
        end
        rem_rd_reg <= rem_mem[rd_idx];
        rel_rd_reg <= rel_mem[rd_idx];
    end

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign scan_done = scan_found_reg || (scan_idx_reg == SCAN_END);
    assign scan_free = (scan_idx_reg < SCAN_END)
                    && (mode_reg[scan_idx_reg[IDX_W-1:0]] == mst_pkg::MODE_FREE);
    assign ex_mode   = mode_reg[ex_idx_reg];
    assign rem_dec   = rem_rd_reg - COUNT_WIDTH'(1);
    assign ex_last   = (ex_idx_reg == LAST_IDX);

    always_comb
    begin
        state_next        = state_reg;
        ex_idx_next       = ex_idx_reg;
        scan_idx_next     = scan_idx_reg;
        scan_found_next   = scan_found_reg;
        pend_valid_next   = pend_valid_reg;
        pend_id_next      = pend_id_reg;
        mode_oneshot_next = mode_oneshot_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        rsp_next          = rsp_reg;
        mode_we           = 1'b0;
        mode_wa           = ex_idx_reg;
        mode_wd           = mst_pkg::MODE_FREE;
        rem_we            = 1'b0;
        rel_we            = 1'b0;
        mem_wa            = ex_idx_reg;
        rem_wd            = rem_dec;
        rd_idx            = ex_idx_reg;
        div_start         = 1'b0;
        req_ready         = 1'b0;

        case (state_reg)
            mst_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                rd_idx    = '0;
                if (req_valid)
                begin
                    if (req.cmd == mst_pkg::CMD_CREATE)
                    begin
                        div_start         = 1'b1;
                        scan_idx_next     = '0;
                        scan_found_next   = 1'b0;
                        mode_oneshot_next = (req.repeat_mode == mst_pkg::REPEAT_ONESHOT);
                        state_next        = mst_pkg::ST_CREATE;
                    end
                    else
                    begin
                        // slot zero is read this cycle
                        ex_idx_next     = '0;
                        pend_valid_next = 1'b0;
                        state_next      = mst_pkg::ST_TICK;
                    end
                end
            end

            mst_pkg::ST_CREATE:
            begin
                // free-slot scan, one slot a cycle, next to the divider
                if (!scan_done)
                begin
                    if (scan_free)
                    begin
                        scan_found_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + CNT_W'(1);
                    end
                end
                else if (!div_busy && out_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.kind      = mst_pkg::KIND_CREATE;
                    rsp_next.last      = 1'b1;
                    rsp_next.create_ok = scan_found_reg;
                    rsp_next.timer_id  = '0;
                    if (scan_found_reg)
                    begin
                        rsp_next.timer_id = to_id(scan_idx_reg[IDX_W-1:0]);
                        mode_we = 1'b1;
                        mode_wa = scan_idx_reg[IDX_W-1:0];
                        mode_wd = mode_oneshot_reg ? mst_pkg::MODE_ONESHOT
                                                   : mst_pkg::MODE_PERIODIC;
                        mem_wa  = scan_idx_reg[IDX_W-1:0];
                        rem_we  = 1'b1;
                        rel_we  = 1'b1;
                        rem_wd  = div_secs;
                    end
                    state_next = mst_pkg::ST_IDLE;
                end
            end

            mst_pkg::ST_TICK:
            begin
                if (ex_mode == mst_pkg::MODE_FREE)
                begin
                    // nothing to count, move on
                end
                else if (rem_dec != '0)
                begin
                    rem_we = 1'b1;
                    rem_wd = rem_dec;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // flush the held expiry, hold this one until the next is known
                    if (pend_valid_reg)
                    begin
                        rsp_valid_next     = 1'b1;
                        rsp_next.kind      = mst_pkg::KIND_EXPIRY;
                        rsp_next.timer_id  = to_id(pend_id_reg);
                        rsp_next.create_ok = 1'b0;
                        rsp_next.last      = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = ex_idx_reg;
                    if (ex_mode == mst_pkg::MODE_ONESHOT)
                    begin
                        mode_we = 1'b1;
                        mode_wd = mst_pkg::MODE_FREE;
                    end
                    else
                    begin
                        rem_we = 1'b1;
                        rem_wd = rel_rd_reg;
                    end
                end

                // advance unless an expiry is stalled on the output register
                if (!((ex_mode != mst_pkg::MODE_FREE) && (rem_dec == '0)
                      && pend_valid_reg && !out_free))
                begin
                    if (ex_last)
                    begin
                        state_next = mst_pkg::ST_TICK_END;
                    end
                    else
                    begin
                        ex_idx_next = ex_idx_reg + IDX_W'(1);
                        rd_idx      = ex_idx_reg + IDX_W'(1);
                    end
                end
            end

            mst_pkg::ST_TICK_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = mst_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.kind      = mst_pkg::KIND_EXPIRY;
                    rsp_next.timer_id  = to_id(pend_id_reg);
                    rsp_next.create_ok = 1'b0;
                    rsp_next.last      = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = mst_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mst_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[tb/sv/multi_slot_second_timer_unit_test.sv]
// ---------------------------------------------------------------------------
// multi_slot_second_timer_unit_test: self-checking bench of the second timer
// drives create and tick items through the request channel, predicts every
// create reply and expiry with its own copy of the slot table, and checks
// each response item in order under random sender gaps and receiver stalls
// ---------------------------------------------------------------------------
module multi_slot_second_timer_unit_test;

    // block configuration under test
    localparam int TIMER_SLOTS = 32;
    localparam int COUNT_W     = 23;
    localparam int MS_W        = mst_pkg::MS_W;
    localparam int REQ_W       = $bits(mst_pkg::req_item_t);

    // rounding of milliseconds to whole seconds
    localparam logic [MS_W:0] ROUND_UP_MS = (MS_W + 1)'(900);
    localparam logic [MS_W:0] MS_PER_SEC  = (MS_W + 1)'(1000);
    localparam logic [MS_W:0] COUNT_MAX   = ((MS_W + 1)'(1) << COUNT_W) - 1'b1;

    // run shape
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_ITEMS    = 266;
    localparam int HOLD_OFF_AFTER  = 100;     // accepted requests before the long stall
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES     = 120;     // longer than one create or one tick walk
    localparam int CYCLE_LIMIT     = 600000;
    localparam int SHOW_LIMIT      = 10;

    // -----------------------------------------------------------------------
    // slot table copy, expected response items and their checking
    // -----------------------------------------------------------------------
    class timer_scoreboard;
        mst_pkg::slot_mode_t slot_state[TIMER_SLOTS];
        logic [COUNT_W-1:0]  secs_left[TIMER_SLOTS];
        logic [COUNT_W-1:0]  secs_reload[TIMER_SLOTS];
        mst_pkg::rsp_item_t  expected_events[$];
        int                  errors;
        int                  shown;

        function new();
            foreach (slot_state[i])
            begin
                slot_state[i] = mst_pkg::MODE_FREE;
            end
            errors = 0;
            shown  = 0;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        // works out the response items that one accepted request causes
        function void note_request(mst_pkg::req_item_t it);
            logic [MS_W:0]      secs;
            mst_pkg::rsp_item_t ev;
            mst_pkg::rsp_item_t batch[$];
            bit                 placed;
            placed = 1'b0;
            if (it.cmd == mst_pkg::CMD_CREATE)
            begin
                secs = ({1'b0, it.duration_ms} + ROUND_UP_MS) / MS_PER_SEC;
                // zero seconds would step past zero, so one is the floor
                if (secs == '0)
                    secs = (MS_W + 1)'(1);
                if (secs > COUNT_MAX)
                    secs = COUNT_MAX;
                ev      = '0;
                ev.kind = mst_pkg::KIND_CREATE;
                ev.last = 1'b1;
                for (int i = 0; i < TIMER_SLOTS && !placed; i++)
                begin
                    if (slot_state[i] == mst_pkg::MODE_FREE)
                    begin
                        slot_state[i]  = (it.repeat_mode == mst_pkg::REPEAT_ONESHOT) ?
                                         mst_pkg::MODE_ONESHOT : mst_pkg::MODE_PERIODIC;
                        secs_left[i]   = secs[COUNT_W-1:0];
                        secs_reload[i] = secs[COUNT_W-1:0];
                        ev.timer_id    = 5'(i);
                        ev.create_ok   = 1'b1;
                        placed         = 1'b1;
                    end
                end
                expected_events.push_back(ev);
            end
            else
            begin
                for (int i = 0; i < TIMER_SLOTS; i++)
                begin
                    if (slot_state[i] != mst_pkg::MODE_FREE)
                    begin
                        secs_left[i] = secs_left[i] - 1'b1;
                        if (secs_left[i] == '0)
                        begin
                            ev          = '0;
                            ev.kind     = mst_pkg::KIND_EXPIRY;
                            ev.timer_id = 5'(i);
                            batch.push_back(ev);
                            if (slot_state[i] == mst_pkg::MODE_ONESHOT)
                            begin
                                slot_state[i]  = mst_pkg::MODE_FREE;
                                secs_reload[i] = '0;
                            end
                            else
                            begin
                                secs_left[i] = secs_reload[i];
                            end
                        end
                    end
                end
                if (batch.size() > 0)
                    batch[batch.size() - 1].last = 1'b1;
                foreach (batch[j])
                begin
                    expected_events.push_back(batch[j]);
                end
            end
        endfunction

        // compares one accepted response item with the oldest expectation
        function void check_response(mst_pkg::rsp_item_t got);
            mst_pkg::rsp_item_t want;
            if (expected_events.size() == 0)
            begin
                errors++;
                if (shown < SHOW_LIMIT)
                begin
                    shown++;
                    $display("unexpected response item: kind %0d id %0d ok %0d last %0d",
                             got.kind, got.timer_id, got.create_ok, got.last);
                end
            end
            else
            begin
                want = expected_events.pop_front();
                if (got.kind !== want.kind || got.timer_id !== want.timer_id ||
                    got.create_ok !== want.create_ok || got.last !== want.last)
                begin
                    errors++;
                    if (shown < SHOW_LIMIT)
                    begin
                        shown++;
                        $display("response mismatch: expected kind %0d id %0d ok %0d last %0d,",
                                 want.kind, want.timer_id, want.create_ok, want.last,
                                 " got kind %0d id %0d ok %0d last %0d",
                                 got.kind, got.timer_id, got.create_ok, got.last);
                    end
                end
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // signals, the block's inputs driven to known values from time zero
    // -----------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    mst_pkg::req_item_t req       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    mst_pkg::rsp_item_t rsp;

    timer_scoreboard    sb;
    mst_pkg::req_item_t stimulus[$];
    int                 accepted_requests = 0;
    int                 cycle_count       = 0;

    multi_slot_second_timer_unit #(
        .SLOTS       (TIMER_SLOTS),
        .COUNT_WIDTH (COUNT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // period of two time units
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // item builders
    // -----------------------------------------------------------------------
    function automatic mst_pkg::req_item_t make_create(logic mode, logic [MS_W-1:0] ms);
        mst_pkg::req_item_t it;
        it.cmd         = mst_pkg::CMD_CREATE;
        it.repeat_mode = mode;
        it.duration_ms = ms;
        return it;
    endfunction

    // ignored fields of a tick still carry random bits
    function automatic mst_pkg::req_item_t make_tick();
        mst_pkg::req_item_t it;
        it.cmd         = mst_pkg::CMD_TICK;
        it.repeat_mode = 1'($urandom);
        it.duration_ms = $urandom;
        return it;
    endfunction

    // mostly a few seconds so timers keep expiring, now and then full range
    function automatic logic [MS_W-1:0] random_duration();
        logic [MS_W-1:0] ms;
        case ($urandom_range(0, 19))
            0:       ms = $urandom;
            1:       ms = $urandom_range(0, 999);
            2:       ms = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: ms = $urandom_range(0, 6000);
        endcase
        return ms;
    endfunction

    // holds valid and payload until the item is taken at a rising edge
    task automatic send_item(input mst_pkg::req_item_t it);
        req       <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // -----------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge, before any update
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                sb.note_request(req);
                accepted_requests++;
            end
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
        end
    end

    // -----------------------------------------------------------------------
    // receiver: segments of always ready, coin flip, rare ready and toggle,
    // plus one long hold-off that lets the block back up into its input
    // -----------------------------------------------------------------------
    initial
    begin
        int  seg_kind;
        int  seg_len;
        bit  held_off;
        bit  toggle;
        held_off = 1'b0;
        toggle   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            seg_kind = $urandom_range(0, 3);
            seg_len  = $urandom_range(10, 60);
            for (int k = 0; k < seg_len; k++)
            begin
                @(posedge clk);
                if (!held_off && accepted_requests >= HOLD_OFF_AFTER)
                begin
                    held_off = 1'b1;
                    rsp_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
                else
                begin
                    toggle = !toggle;
                    case (seg_kind)
                        0:       rsp_ready <= 1'b1;
                        1:       rsp_ready <= 1'($urandom);
                        2:       rsp_ready <= ($urandom_range(0, 5) == 0);
                        default: rsp_ready <= toggle;
                    endcase
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // run limit
    // -----------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("multi_slot_second_timer_unit_test: done, errors");
        $finish;
    end

    // -----------------------------------------------------------------------
    // stimulus and end of run
    // -----------------------------------------------------------------------
    initial
    begin
        int idx;
        int burst_len;
        int gap;
        int choice;
        int n_create;
        int n_tick;
        int goal;
        sb = new();

        // directed: empty tick, zero and sub-second durations, longest
        // duration, lowest free slot reuse, several expiries in one tick
        stimulus.push_back(make_tick());                                        // quiet tick
        stimulus.push_back(make_create(mst_pkg::REPEAT_ONESHOT, 32'd0));         // zero ms
        stimulus.push_back(make_create(mst_pkg::REPEAT_PERIODIC, 32'd99));       // rounds to zero
        stimulus.push_back(make_create(mst_pkg::REPEAT_ONESHOT, 32'd100));       // one second
        stimulus.push_back(make_create(mst_pkg::REPEAT_PERIODIC, 32'hFFFF_FFFF));// longest
        stimulus.push_back(make_create(mst_pkg::REPEAT_ONESHOT, 32'd1100));
        stimulus.push_back(make_create(mst_pkg::REPEAT_PERIODIC, 32'd2099));
        stimulus.push_back(make_tick());                                        // three expiries
        stimulus.push_back(make_create(mst_pkg::REPEAT_ONESHOT, 32'd1000));      // reuses slot 0
        stimulus.push_back(make_tick());
        stimulus.push_back(make_tick());
        stimulus.push_back(make_create(mst_pkg::REPEAT_PERIODIC, 32'd900));
        stimulus.push_back(make_create(mst_pkg::REPEAT_ONESHOT, 32'd1099));
        stimulus.push_back(make_tick());

        // random: mostly a few creates followed by a run of ticks, some noise
        goal = stimulus.size() + RANDOM_ITEMS;
        while (stimulus.size() < goal)
        begin
            choice = $urandom_range(0, 9);
            if (choice == 0)
            begin
                n_create = $urandom_range(1, 4);
                for (int k = 0; k < n_create; k++)
                begin
                    stimulus.push_back(mst_pkg::req_item_t'(REQ_W'({$urandom, $urandom})));
                end
            end
            else
            begin
                n_create = $urandom_range(0, 3);
                n_tick   = $urandom_range(1, 5);
                for (int k = 0; k < n_create; k++)
                begin
                    // one-shots dominate so slots keep freeing up
                    stimulus.push_back(make_create(
                        ($urandom_range(0, 4) == 0) ? mst_pkg::REPEAT_PERIODIC
                                                     : mst_pkg::REPEAT_ONESHOT,
                        random_duration()));
                end
                for (int k = 0; k < n_tick; k++)
                begin
                    stimulus.push_back(make_tick());
                end
            end
        end

        // single reset at the start
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bursts of random length with random gaps, now and then a long
        // burst with no gap at all
        idx = 0;
        while (idx < stimulus.size())
        begin
            burst_len = ($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 10);
            for (int k = 0; k < burst_len && idx < stimulus.size(); k++)
            begin
                send_item(stimulus[idx]);
                idx++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_valid <= 1'b0;

        // let the monitor note the last item, drain, then watch for strays
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("multi_slot_second_timer_unit_test: done, clean");
        else
            $display("multi_slot_second_timer_unit_test: done, errors");
        $finish;
    end

endmodule
